// ===== rtl/pca_pkg.sv =====
package pca_pkg;

   localparam int MAX_PAGES     = 4096;
   localparam int MAX_RECORDS   = 256;
   localparam int PAGE_BYTES    = 4096;
   localparam int INITIAL_PAGES = 4096;

   localparam int PAGE_W   = $clog2(MAX_PAGES);
   localparam int CNT_W    = PAGE_W + 1;
   localparam int SLOT_W   = $clog2(MAX_RECORDS);
   localparam int LINK_W   = 14;
   localparam int OFFS_W   = $clog2(PAGE_BYTES);
   localparam int BYTES_W  = 31;
   localparam int WANT_W   = BYTES_W - OFFS_W + 1;
   localparam int TARGET_W = BYTES_W - OFFS_W;

   localparam logic [CNT_W-1:0] MAX_PAGES_C = CNT_W'(MAX_PAGES);
   localparam logic [CNT_W-1:0] INIT_PAGES_C =
      CNT_W'(INITIAL_PAGES > MAX_PAGES ? MAX_PAGES : INITIAL_PAGES);
   localparam logic [12:0] GROW_RESET = 13'd4096;

   localparam logic [LINK_W-1:0] LINK_FREE      = LINK_W'(0);
   localparam logic [LINK_W-1:0] LINK_END       = LINK_W'(1);
   localparam logic [LINK_W-1:0] LINK_NEXT_BASE = LINK_W'(2);

   localparam logic [2:0] OP_CREATE = 3'd0;
   localparam logic [2:0] OP_DELETE = 3'd1;
   localparam logic [2:0] OP_APPEND = 3'd2;
   localparam logic [2:0] OP_LOCATE = 3'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_SLOT   = 3'd1;
   localparam logic [2:0] ST_NO_PAGE   = 3'd2;
   localparam logic [2:0] ST_BEYOND    = 3'd3;
   localparam logic [2:0] ST_NO_RECORD = 3'd4;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  handle;
      logic [30:0] byte_count;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  slot;
      logic [11:0] page;
      logic [12:0] free_count;
   } rsp_type;

endpackage

// ===== rtl/pca_ram.sv =====
module pca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/page_chain_allocator.sv =====
// channel  direction  handshake          payload
// req      in         req_valid/stall    pca_pkg::req_type
// rsp      out        rsp_valid/stall    pca_pkg::rsp_type
// csr      in         csr_valid/ready    grow_pages, 13 bits
//
// one word at a time; unknown and no-record words go straight to the response, others
// walk the page link ram, one read per page visited or scanned (single read port)
// create also scans slot live bits, one per cycle, up to 256
// reset is synchronous; all slots free, then a clearing pass over all 4096 pages marks
// every page free while req_stall stays high
// a held result does not block acceptance of the next word
module page_chain_allocator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pca_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pca_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [12:0]       csr_data
);
   import pca_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SLOT     = 4'd1;
   localparam logic [3:0] S_HEAD     = 4'd2;
   localparam logic [3:0] S_SCAN_RD  = 4'd3;
   localparam logic [3:0] S_SCAN_CHK = 4'd4;
   localparam logic [3:0] S_TAKE     = 4'd5;
   localparam logic [3:0] S_LINK     = 4'd6;
   localparam logic [3:0] S_COMMIT   = 4'd7;
   localparam logic [3:0] S_FREE_RD  = 4'd8;
   localparam logic [3:0] S_FREE_CHK = 4'd9;
   localparam logic [3:0] S_WALK_RD  = 4'd10;
   localparam logic [3:0] S_WALK_CHK = 4'd11;
   localparam logic [3:0] S_DONE     = 4'd12;
   localparam logic [3:0] S_CLEAR    = 4'd13;

   logic [3:0]            state_ff, state_in;
   logic [PAGE_W-1:0]     clr_ff, clr_in;
   logic [2:0]            op_ff, op_in;
   logic [SLOT_W-1:0]     handle_ff, handle_in;
   logic [BYTES_W-1:0]    bytes_ff, bytes_in;
   logic [MAX_RECORDS-1:0] live_ff, live_in;
   logic [SLOT_W:0]       shm_ff, shm_in;
   logic [CNT_W-1:0]      active_ff, active_in;
   logic [CNT_W-1:0]      used_ff, used_in;
   logic [12:0]           grow_ff, grow_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic                  grown_ff, grown_in;
   logic [PAGE_W-1:0]     np_ff, np_in;
   logic [PAGE_W-1:0]     prev_ff, prev_in;
   logic [PAGE_W-1:0]     head_ff, head_in;
   logic [PAGE_W-1:0]     p_ff, p_in;
   logic [WANT_W-1:0]     want_ff, want_in;
   logic [WANT_W-1:0]     k_ff, k_in;
   logic [TARGET_W-1:0]   idx_ff, idx_in;
   logic [2:0]            status_ff, status_in;
   logic [PAGE_W-1:0]     page_ff, page_in;
   logic [SLOT_W-1:0]     oslot_ff, oslot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  link_we;
   logic [PAGE_W-1:0]     link_waddr, link_raddr;
   logic [LINK_W-1:0]     link_wdata, link_rdata;
   logic                  rec_we;
   logic [PAGE_W-1:0]     rec_rdata;
   logic                  accept;
   logic                  next_ok;
   logic [PAGE_W-1:0]     next_pg;
   logic [CNT_W:0]        grown_sum;
   logic [WANT_W-1:0]     want_raw;
   logic [LINK_W-1:0]     np_link;

   pca_ram #(.WIDTH(LINK_W), .DEPTH(MAX_PAGES)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   pca_ram #(.WIDTH(PAGE_W), .DEPTH(MAX_RECORDS)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (slot_ff),
      .wr_data (head_ff),
      .rd_addr (req_data.handle),
      .rd_data (rec_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign next_ok   = (link_rdata >= LINK_NEXT_BASE) &&
                      ((link_rdata - LINK_NEXT_BASE) < LINK_W'(MAX_PAGES));
   assign next_pg   = PAGE_W'(link_rdata - LINK_NEXT_BASE);
   assign grown_sum = {1'b0, active_ff} + (CNT_W + 1)'(grow_ff);
   assign want_raw  = WANT_W'(bytes_ff[BYTES_W-1:OFFS_W]) + WANT_W'(|bytes_ff[OFFS_W-1:0]);
   assign np_link   = LINK_W'(np_ff) + LINK_NEXT_BASE;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      op_in     = op_ff;
      handle_in = handle_ff;
      bytes_in  = bytes_ff;
      live_in   = live_ff;
      shm_in    = shm_ff;
      active_in = active_ff;
      used_in   = used_ff;
      grow_in   = grow_ff;
      slot_in   = slot_ff;
      scan_in   = scan_ff;
      grown_in  = grown_ff;
      np_in     = np_ff;
      prev_in   = prev_ff;
      head_in   = head_ff;
      p_in      = p_ff;
      want_in   = want_ff;
      k_in      = k_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      page_in   = page_ff;
      oslot_in  = oslot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in    = rsp_ff;
      link_we    = 1'b0;
      link_waddr = np_ff;
      link_wdata = LINK_END;
      link_raddr = p_ff;
      rec_we     = 1'b0;

      if (csr_valid && csr_ready) begin
         grow_in = csr_data;
      end

      case (state_ff)
         S_CLEAR: begin
            link_we    = 1'b1;
            link_waddr = clr_ff;
            link_wdata = LINK_FREE;
            clr_in     = clr_ff + PAGE_W'(1);
            if (clr_ff == PAGE_W'(MAX_PAGES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in     = req_data.operation;
               handle_in = req_data.handle;
               bytes_in  = req_data.byte_count;
               status_in = ST_OK;
               page_in   = '0;
               oslot_in  = '0;
               slot_in   = '0;
               if (req_data.operation == OP_CREATE) begin
                  state_in = S_SLOT;
               end else if (req_data.operation == OP_DELETE ||
                            req_data.operation == OP_APPEND ||
                            req_data.operation == OP_LOCATE) begin
                  if (live_ff[req_data.handle]) begin
                     state_in = S_HEAD;
                  end else begin
                     status_in = ST_NO_RECORD;
                     state_in  = S_DONE;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SLOT: begin
            if (!live_ff[slot_ff]) begin
               want_in  = (want_raw == '0) ? WANT_W'(1) : want_raw;
               k_in     = '0;
               scan_in  = '0;
               grown_in = 1'b0;
               state_in = S_SCAN_RD;
            end else if (slot_ff == SLOT_W'(MAX_RECORDS - 1)) begin
               status_in = ST_NO_SLOT;
               state_in  = S_DONE;
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
            end
         end
         S_HEAD: begin
            p_in   = rec_rdata;
            idx_in = '0;
            if (op_ff == OP_DELETE) begin
               state_in = S_FREE_RD;
            end else begin
               state_in = S_WALK_RD;
            end
         end
         S_SCAN_RD: begin
            link_raddr = scan_ff[PAGE_W-1:0];
            if (scan_ff >= active_ff) begin
               if (!grown_ff && active_ff < MAX_PAGES_C) begin
                  grown_in  = 1'b1;
                  active_in = (grown_sum > (CNT_W + 1)'(MAX_PAGES)) ?
                              MAX_PAGES_C : grown_sum[CNT_W-1:0];
               end else begin
                  status_in = ST_NO_PAGE;
                  if (op_ff == OP_CREATE && k_ff != '0) begin
                     p_in     = head_ff;
                     state_in = S_FREE_RD;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            end else begin
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (link_rdata == LINK_FREE) begin
               np_in    = scan_ff[PAGE_W-1:0];
               state_in = S_TAKE;
            end else begin
               scan_in  = scan_ff + CNT_W'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_TAKE: begin
            link_we    = 1'b1;
            link_waddr = np_ff;
            link_wdata = LINK_END;
            used_in    = used_ff + CNT_W'(1);
            if (op_ff == OP_CREATE && k_ff == '0) begin
               head_in  = np_ff;
               prev_in  = np_ff;
               k_in     = k_ff + WANT_W'(1);
               if (k_ff + WANT_W'(1) == want_ff) begin
                  state_in = S_COMMIT;
               end else begin
                  scan_in  = CNT_W'(np_ff) + CNT_W'(1);
                  grown_in = 1'b0;
                  state_in = S_SCAN_RD;
               end
            end else begin
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            link_we    = 1'b1;
            link_waddr = prev_ff;
            link_wdata = np_link;
            if (op_ff == OP_APPEND) begin
               page_in  = np_ff;
               state_in = S_DONE;
            end else begin
               prev_in = np_ff;
               k_in    = k_ff + WANT_W'(1);
               if (k_ff + WANT_W'(1) == want_ff) begin
                  state_in = S_COMMIT;
               end else begin
                  scan_in  = CNT_W'(np_ff) + CNT_W'(1);
                  grown_in = 1'b0;
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_COMMIT: begin
            rec_we           = 1'b1;
            live_in[slot_ff] = 1'b1;
            if ({1'b0, slot_ff} >= shm_ff) begin
               shm_in = shm_ff + (SLOT_W + 1)'(1);
            end
            oslot_in = slot_ff;
            page_in  = head_ff;
            state_in = S_DONE;
         end
         S_FREE_RD: begin
            link_raddr = p_ff;
            state_in   = S_FREE_CHK;
         end
         S_FREE_CHK: begin
            link_we    = 1'b1;
            link_waddr = p_ff;
            link_wdata = LINK_FREE;
            if (link_rdata != LINK_FREE) begin
               used_in = used_ff - CNT_W'(1);
            end
            if (next_ok) begin
               p_in     = next_pg;
               state_in = S_FREE_RD;
            end else begin
               if (op_ff == OP_DELETE) begin
                  live_in[handle_ff] = 1'b0;
                  if (shm_ff != '0 && {1'b0, handle_ff} == shm_ff - (SLOT_W + 1)'(1)) begin
                     shm_in = shm_ff - (SLOT_W + 1)'(1);
                  end
               end
               state_in = S_DONE;
            end
         end
         S_WALK_RD: begin
            link_raddr = p_ff;
            if (op_ff == OP_LOCATE && idx_ff == bytes_ff[BYTES_W-1:OFFS_W]) begin
               page_in  = p_ff;
               state_in = S_DONE;
            end else begin
               state_in = S_WALK_CHK;
            end
         end
         S_WALK_CHK: begin
            if (next_ok) begin
               p_in     = next_pg;
               idx_in   = idx_ff + TARGET_W'(1);
               state_in = S_WALK_RD;
            end else if (op_ff == OP_APPEND) begin
               prev_in  = p_ff;
               scan_in  = '0;
               grown_in = 1'b0;
               state_in = S_SCAN_RD;
            end else begin
               status_in = ST_BEYOND;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = status_ff;
               rsp_in.slot         = oslot_ff;
               rsp_in.page         = page_ff;
               rsp_in.free_count   = active_ff - used_ff;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         live_ff      <= '0;
         shm_ff       <= '0;
         active_ff    <= INIT_PAGES_C;
         used_ff      <= '0;
         grow_ff      <= GROW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         live_ff      <= live_in;
         shm_ff       <= shm_in;
         active_ff    <= active_in;
         used_ff      <= used_in;
         grow_ff      <= grow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff     <= op_in;
      handle_ff <= handle_in;
      bytes_ff  <= bytes_in;
      slot_ff   <= slot_in;
      scan_ff   <= scan_in;
      grown_ff  <= grown_in;
      np_ff     <= np_in;
      prev_ff   <= prev_in;
      head_ff   <= head_in;
      p_ff      <= p_in;
      want_ff   <= want_in;
      k_ff      <= k_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      page_ff   <= page_in;
      oslot_ff  <= oslot_in;
      rsp_ff    <= rsp_in;
   end

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= active_ff)
      else $error("more pages in use than active");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("accepted word did not start work");

   a_take_in_region: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TAKE |-> CNT_W'(np_ff) < active_ff)
      else $error("page taken outside active region");

   a_commit_free_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COMMIT |-> !live_ff[slot_ff])
      else $error("create committed onto a live slot");

endmodule
